/* hw/rtl/qrs_pkg.sv */
// Shared types and constants for the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;

	// Root count codes
	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	// Fixed datapath widths
	localparam int ROOT_W = 34;   // floor sqrt of a 66-bit discriminant
	localparam int DISC_W = 66;   // exact b*b - 4ac magnitude
	localparam int DEN_W  = 33;   // 2*|a|
	localparam int QUO_W  = 33;   // quotient bits kept after the overflow check
	localparam int SQR_W  = 38;   // square root partial remainder

	// Input beat
	typedef struct packed {
		logic signed [31:0] coef_a;
		logic signed [31:0] coef_b;
		logic signed [31:0] coef_c;
	} coef_t;

	// Output beat
	typedef struct packed {
		logic [1:0]         root_count;
		logic signed [31:0] root_plus;
		logic signed [31:0] root_minus;
		logic               degenerate;
		logic               overflow;
	} root_t;

	// Per-item side data that travels down the pipeline
	typedef struct packed {
		logic [1:0]         cnt;
		logic               deg;
		logic               a_neg;
		logic signed [31:0] b;
		logic [DEN_W-1:0]   den;
	} side_t;

endpackage

/* hw/rtl/qrs_coef_if.sv */
// Coefficient channel: valid/ready handshake with one coefficient triple per beat.
`timescale 1ns / 1ps
interface qrs_coef_if;
	logic          valid;
	logic          ready;
	qrs_pkg::coef_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/qrs_root_if.sv */
// Root channel: valid/ready handshake with one solver result per beat.
`timescale 1ns / 1ps
interface qrs_root_if;
	logic          valid;
	logic          ready;
	qrs_pkg::root_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/quadratic_root_solver.sv */
// Pipelined real-root solver for a*x^2 + b*x + c = 0 in signed fixed point.
`timescale 1ns / 1ps
// Takes one coefficient beat per cycle while the output is not stalled and returns one result
// beat per input, in order. Its depth comes from the 34-step square root
// and the 34-step restoring divider (overflow check plus 33 quotient bits), each step one
// register stage; both roots are divided in parallel lanes. All stages move together: when
// the output beat is not taken, the whole pipeline holds and the input is not ready.
module quadratic_root_solver #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	qrs_coef_if.sink     coef,
	qrs_root_if.source   roots
);
	localparam int NW    = qrs_pkg::ROOT_W + FRAC_BITS;   // scaled numerator width
	localparam int RW    = (NW > 66) ? NW : 66;           // divider remainder width
	localparam int SQ_N  = qrs_pkg::ROOT_W;               // square root steps
	localparam int DV_N  = qrs_pkg::QUO_W + 1;            // check + quotient steps
	localparam int VW    = 2 * qrs_pkg::ROOT_W;           // padded radicand width

	logic en;
	assign en         = !roots.valid || roots.ready;
	assign coef.ready = en;

	// Stage 1: input register
	logic               v_s1;
	logic signed [31:0] a_s1, b_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= coef.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= coef.data.coef_a;
			b_s1 <= coef.data.coef_b;
			c_s1 <= coef.data.coef_c;
		end
	end

	// Stage 2: magnitudes and the two products
	logic [31:0] ma, mb, mc;
	assign ma = a_s1[31] ? (~a_s1 + 32'd1) : a_s1;
	assign mb = b_s1[31] ? (~b_s1 + 32'd1) : b_s1;
	assign mc = c_s1[31] ? (~c_s1 + 32'd1) : c_s1;

	logic                v_s2;
	logic [63:0]         bb_s2, p_s2;
	logic                diff_s2;
	qrs_pkg::side_t      side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s2         <= mb * mb;
			p_s2          <= ma * mc;
			diff_s2       <= a_s1[31] ^ c_s1[31];
			side_s2.cnt   <= qrs_pkg::CNT_NONE;
			side_s2.deg   <= (a_s1 == 32'sd0);
			side_s2.a_neg <= a_s1[31];
			side_s2.b     <= b_s1;
			side_s2.den   <= {ma, 1'b0};
		end
	end

	// Stage 3: discriminant and root count
	logic [qrs_pkg::DISC_W-1:0] bb_w, p4_w, disc;
	logic                       disc_neg;
	logic [1:0]                 cnt_s2;
	qrs_pkg::side_t             side_c;
	assign bb_w = {2'b00, bb_s2};
	assign p4_w = {p_s2, 2'b00};

	always_comb begin
		disc_neg = 1'b0;
		if (diff_s2) begin
			disc = bb_w + p4_w;
		end else if (p4_w > bb_w) begin
			disc     = '0;
			disc_neg = 1'b1;
		end else begin
			disc = bb_w - p4_w;
		end
		if (side_s2.deg || disc_neg) begin
			cnt_s2 = qrs_pkg::CNT_NONE;
		end else if (disc == '0) begin
			cnt_s2 = qrs_pkg::CNT_ONE;
		end else begin
			cnt_s2 = qrs_pkg::CNT_TWO;
		end
	end

	// side data with the root count filled in
	always_comb begin
		side_c     = side_s2;
		side_c.cnt = cnt_s2;
	end

	// Square root pipeline, two radicand bits per stage
	logic                       sq_v    [0:SQ_N];
	logic [VW-1:0]              sq_rad  [0:SQ_N];
	logic [qrs_pkg::SQR_W-1:0]  sq_rem  [0:SQ_N];
	logic [qrs_pkg::ROOT_W-1:0] sq_root [0:SQ_N];
	qrs_pkg::side_t             sq_side [0:SQ_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (en) begin
			sq_v[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rad[0]  <= {2'b00, disc};
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			sq_side[0] <= side_c;
		end
	end

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		logic [qrs_pkg::SQR_W-1:0] cur, trial;
		logic                      fits;
		assign cur   = {sq_rem[k][qrs_pkg::SQR_W-3:0], sq_rad[k][VW-1 -: 2]};
		assign trial = {{(qrs_pkg::SQR_W - qrs_pkg::ROOT_W - 2){1'b0}}, sq_root[k], 2'b01};
		assign fits  = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (en) begin
				sq_v[k+1] <= sq_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad[k+1]  <= {sq_rad[k][VW-3:0], 2'b00};
				sq_rem[k+1]  <= fits ? (cur - trial) : cur;
				sq_root[k+1] <= {sq_root[k][qrs_pkg::ROOT_W-2:0], fits};
				sq_side[k+1] <= sq_side[k];
			end
		end
	end

	// Numerators -b + s and -b - s, split into sign and scaled magnitude
	logic signed [35:0] nb, sx, np, nm;
	logic [35:0]        mag_p, mag_m;
	assign nb    = -{{4{sq_side[SQ_N].b[31]}}, sq_side[SQ_N].b};
	assign sx    = {2'b00, sq_root[SQ_N]};
	assign np    = nb + sx;
	assign nm    = nb - sx;
	assign mag_p = np[35] ? -np : np;
	assign mag_m = nm[35] ? -nm : nm;

	// Divider pipeline, lane 0 for the plus root, lane 1 for the minus root
	logic                        dv_v    [0:DV_N];
	qrs_pkg::side_t              dv_side [0:DV_N];
	logic [RW-1:0]               dv_rem  [0:1][0:DV_N];
	logic [qrs_pkg::QUO_W-1:0]   dv_q    [0:1][0:DV_N];
	logic                        dv_big  [0:1][0:DV_N];
	logic                        dv_neg  [0:1][0:DV_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= sq_v[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side[0]   <= sq_side[SQ_N];
			dv_rem[0][0] <= RW'(mag_p[qrs_pkg::ROOT_W-1:0]) << FRAC_BITS;
			dv_rem[1][0] <= RW'(mag_m[qrs_pkg::ROOT_W-1:0]) << FRAC_BITS;
			dv_neg[0][0] <= np[35] ^ sq_side[SQ_N].a_neg;
			dv_neg[1][0] <= nm[35] ^ sq_side[SQ_N].a_neg;
			dv_q[0][0]   <= '0;
			dv_q[1][0]   <= '0;
			dv_big[0][0] <= 1'b0;
			dv_big[1][0] <= 1'b0;
		end
	end

	for (genvar j = 0; j < DV_N; j++) begin : g_div
		logic [RW-1:0] dsh;
		if (j == 0) begin : g_chk
			// quotient of 2^33 or more saturates whatever its sign
			assign dsh = RW'(dv_side[j].den) << qrs_pkg::QUO_W;
		end else begin : g_step
			assign dsh = RW'(dv_side[j].den) << (DV_N - 1 - j);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (en) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_side[j+1] <= dv_side[j];
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic fits;
			assign fits = (dv_rem[l][j] >= dsh);

			always_ff @(posedge clk) begin
				if (en) begin
					dv_neg[l][j+1] <= dv_neg[l][j];
					if (j == 0) begin
						dv_rem[l][j+1] <= dv_rem[l][j];
						dv_q[l][j+1]   <= dv_q[l][j];
						dv_big[l][j+1] <= fits;
					end else begin
						dv_rem[l][j+1] <= fits ? (dv_rem[l][j] - dsh) : dv_rem[l][j];
						dv_q[l][j+1]   <= {dv_q[l][j][qrs_pkg::QUO_W-2:0], fits};
						dv_big[l][j+1] <= dv_big[l][j];
					end
				end
			end
		end
	end

	// Saturation and sign per lane
	logic signed [31:0] lane_val [0:1];
	logic               lane_ovf [0:1];

	for (genvar l = 0; l < 2; l++) begin : g_sat
		logic [qrs_pkg::QUO_W-1:0] lim;
		logic [31:0]               qm;
		assign lim = dv_neg[l][DV_N] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
		always_comb begin
			lane_ovf[l] = dv_big[l][DV_N] || (dv_q[l][DV_N] > lim);
			qm          = lane_ovf[l] ? lim[31:0] : dv_q[l][DV_N][31:0];
			lane_val[l] = dv_neg[l][DV_N] ? -qm : qm;
		end
	end

	// Output register
	qrs_pkg::root_t res;
	always_comb begin
		res            = '0;
		res.root_count = dv_side[DV_N].cnt;
		res.degenerate = dv_side[DV_N].deg;
		unique case (dv_side[DV_N].cnt)
			qrs_pkg::CNT_TWO: begin
				res.root_plus  = lane_val[0];
				res.root_minus = lane_val[1];
				res.overflow   = lane_ovf[0] | lane_ovf[1];
			end
			qrs_pkg::CNT_ONE: begin
				res.root_plus = lane_val[0];
				res.overflow  = lane_ovf[0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roots.valid <= 1'b0;
		end else if (en) begin
			roots.valid <= dv_v[DV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roots.data <= res;
		end
	end

endmodule

/* hw/rtl/qrs_checker.sv */
// Port-level checks on the solver's result channel, bound to the top level.
`timescale 1ns / 1ps
module qrs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           valid,
	input logic           ready,
	input qrs_pkg::root_t data
);

	// a stalled beat stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result beat dropped while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (data.root_count == qrs_pkg::CNT_NONE ||
			data.root_count == qrs_pkg::CNT_ONE || data.root_count == qrs_pkg::CNT_TWO))
		else $error("illegal root count");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		valid && data.degenerate |-> data.root_count == qrs_pkg::CNT_NONE &&
			data.root_plus == 32'sd0 && data.root_minus == 32'sd0 && !data.overflow)
		else $error("degenerate beat carries roots");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		valid && data.root_count == qrs_pkg::CNT_NONE |-> data.root_plus == 32'sd0 &&
			!data.overflow)
		else $error("no-root beat carries a root");

	a_minus: assert property (@(posedge clk) disable iff (!arst_n)
		valid && data.root_count != qrs_pkg::CNT_TWO |-> data.root_minus == 32'sd0)
		else $error("minus root set without two roots");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.valid  (roots.valid),
	.ready  (roots.ready),
	.data   (roots.data)
);
